// File: rtl/dep_pkg.sv
// Package for the double-ended priority queue: sizes, codes and shared types.
package dep_pkg;

  // Store depth and derived widths
  localparam int CAPACITY = 256;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  // Top-entry selection is done in groups, one register per group, all in one register stage
  localparam int GROUP    = 16;
  localparam int NGROUP   = (CAPACITY + GROUP - 1) / GROUP;

  typedef logic signed [DATA_W-1:0] data_t;

  // Request command codes; code 3 is a no-op
  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_DEL_MIN = 2'd1,
    CMD_DEL_MAX = 2'd2
  } cmd_t;

  // Operation broadcast to every cell
  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_DEL_MIN = 1'b1
  } cell_op_t;

  typedef struct packed {
    logic     en;
    cell_op_t op;
    data_t    value;
  } cell_ctrl_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SEL  = 2'd1,
    ST_OUT  = 2'd2
  } state_t;

endpackage

// File: rtl/double_ended_priority_queue.sv
// Top level of the double-ended priority queue over signed 32-bit values.
//
// Each request (insert, delete minimum, delete maximum; code 3 is a no-op)
// produces one result with the current maximum, minimum, an empty flag and
// an insert-rejected flag. Values are held ascending in a row of CAPACITY
// cells, the minimum in the first cell; an insert or delete-minimum moves
// the whole row in a single update, and delete-maximum only lowers the count.
// A request passes through three steps: the cell row update, the registered
// per-group selection of the top entry, and the load of the result register,
// which waits while an earlier result is still stalled. The next request is
// taken while a result still waits to be taken. No clearing pass is needed
// after reset.
module double_ended_priority_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_cmd,
  input  logic signed [31:0]    in_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [31:0]    out_max_value,
  output logic signed [31:0]    out_min_value,
  output logic                  out_is_empty,
  output logic                  out_rejected
);
  import dep_pkg::*;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              rej_r, rej_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_load;
  data_t             out_max_r, out_min_r;
  logic              out_empty_r, out_rej_r;
  logic              in_accept;
  logic              full, empty;
  cell_ctrl_t        ctrl;
  data_t             cell_val [CAPACITY];
  logic              cell_gt  [CAPACITY];
  data_t             max_sel;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign full      = (cnt_r == CNT_W'(CAPACITY));
  assign empty     = (cnt_r == '0);

  // Decode the request into the cell broadcast and the new count
  always_comb begin
    ctrl.en    = 1'b0;
    ctrl.op    = OP_INSERT;
    ctrl.value = in_value;
    cnt_nxt    = cnt_r;
    rej_nxt    = rej_r;
    if (in_accept) begin
      rej_nxt = 1'b0;
      case (in_cmd)
        CMD_INSERT: begin
          if (full) begin
            rej_nxt = 1'b1;
          end else begin
            ctrl.en = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        CMD_DEL_MIN: begin
          if (!empty) begin
            ctrl.en = 1'b1;
            ctrl.op = OP_DEL_MIN;
            cnt_nxt = cnt_r - 1'b1;
          end
        end
        CMD_DEL_MAX: begin
          if (!empty) begin
            cnt_nxt = cnt_r - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    data_t below_v;
    logic  below_g;
    data_t above_v;
    if (i == 0) begin : g_bot
      assign below_v = cell_val[0];
      assign below_g = 1'b0;
    end else begin : g_mid
      assign below_v = cell_val[i-1];
      assign below_g = cell_gt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_top
      assign above_v = cell_val[i];
    end else begin : g_low
      assign above_v = cell_val[i+1];
    end
    dep_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ         (cnt_r > CNT_W'(i)),
      .below_value (below_v),
      .below_gt    (below_g),
      .above_value (above_v),
      .value       (cell_val[i]),
      .gt          (cell_gt[i])
    );
  end

  // Top-entry selection
  dep_max_sel u_max_sel (
    .clk       (clk),
    .vals      (cell_val),
    .cnt       (cnt_r),
    .max_value (max_sel)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_load      = 1'b0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_SEL;
        end
      end
      ST_SEL: state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rej_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rej_r       <= rej_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_max_r   <= empty ? '0 : max_sel;
      out_min_r   <= empty ? '0 : cell_val[0];
      out_empty_r <= empty;
      out_rej_r   <= rej_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_max_value = out_max_r;
  assign out_min_value = out_min_r;
  assign out_is_empty  = out_empty_r;
  assign out_rejected  = out_rej_r;

  // Count never exceeds the store depth
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("held count above capacity");

  // A dropped insert leaves the count alone
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_cmd == CMD_INSERT && full) |=> $stable(cnt_r))
    else $error("count moved on rejected insert");

  // Results come only from the output state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result raised outside output state");

  // Row stays sorted: minimum never above maximum
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_empty_r) |-> (out_min_r <= out_max_r))
    else $error("minimum above maximum");

endmodule

// File: rtl/dep_cell.sv
// One cell of the sorted chain: holds one value and shifts with its neighbors.
module dep_cell (
  input  logic                clk,
  input  dep_pkg::cell_ctrl_t ctrl,
  input  logic                occ,
  input  dep_pkg::data_t      below_value,
  input  logic                below_gt,
  input  dep_pkg::data_t      above_value,
  output dep_pkg::data_t      value,
  output logic                gt
);
  import dep_pkg::*;

  data_t value_r;
  data_t value_nxt;

  // Empty cells act as larger than any insert value
  assign gt = !occ || (value_r > ctrl.value);

  // Insert: take neighbor below if it also moves up, else take the new value
  // Delete minimum: take neighbor above
  always_comb begin
    value_nxt = value_r;
    case (ctrl.op)
      OP_INSERT: begin
        if (gt) begin
          value_nxt = below_gt ? below_value : ctrl.value;
        end
      end
      OP_DEL_MIN: value_nxt = above_value;
      default:    value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      value_r <= value_nxt;
    end
  end

  assign value = value_r;

endmodule

// File: rtl/dep_max_sel.sv
// Picks the top held entry (index count-1) out of the cell row, one group stage.
module dep_max_sel (
  input  logic                       clk,
  input  dep_pkg::data_t             vals [dep_pkg::CAPACITY],
  input  logic [dep_pkg::CNT_W-1:0]  cnt,
  output dep_pkg::data_t             max_value
);
  import dep_pkg::*;

  data_t sel [NGROUP*GROUP];
  data_t partial_r [NGROUP];

  // Gate each cell by its top-of-store flag; padding slots read zero
  for (genvar i = 0; i < NGROUP*GROUP; i++) begin : g_sel
    if (i < CAPACITY) begin : g_real
      assign sel[i] = (cnt == CNT_W'(i + 1)) ? vals[i] : '0;
    end else begin : g_pad
      assign sel[i] = '0;
    end
  end

  // Per-group OR, registered
  for (genvar g = 0; g < NGROUP; g++) begin : g_grp
    data_t acc;
    always_comb begin
      acc = '0;
      for (int k = 0; k < GROUP; k++) begin
        acc = acc | sel[g*GROUP + k];
      end
    end
    always_ff @(posedge clk) begin
      partial_r[g] <= acc;
    end
  end

  // Final OR over the group results
  always_comb begin
    max_value = '0;
    for (int g = 0; g < NGROUP; g++) begin
      max_value = max_value | partial_r[g];
    end
  end

endmodule

// File: bench/tb_double_ended_priority_queue.sv
// Self-checking testbench for the double-ended priority queue.
module tb_double_ended_priority_queue;
  import dep_pkg::*;

  // Result of one request as seen on the out_ ports
  typedef struct packed {
    data_t max_value;
    data_t min_value;
    logic  is_empty;
    logic  rejected;
  } queue_result_t;

  // One row of the directed table; want is used only when typed is set
  typedef struct packed {
    logic [1:0]    cmd;
    data_t         value;
    logic          typed;
    queue_result_t want;
  } request_row_t;

  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam data_t MAX_INT = 32'sh7FFFFFFF;
  localparam data_t MIN_INT = 32'sh80000000;
  localparam data_t ALL_ONES = 32'shFFFFFFFF;
  localparam queue_result_t EMPTY_RES = '{32'sd0, 32'sd0, 1'b1, 1'b0};
  localparam queue_result_t NO_RES = '0;
  localparam int N_DIRECTED = 21;
  localparam int PHASE_ITEMS = 350;
  localparam int LONG_HOLD_AT = 200;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 16;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_cmd;
  data_t in_value;
  logic out_valid;
  logic out_stall;
  data_t out_max_value;
  data_t out_min_value;
  logic out_is_empty;
  logic out_rejected;

  data_t held_values[$];
  queue_result_t pending_results[$];
  int mismatch_count = 0;
  int checked_count = 0;
  int result_count = 0;
  bit sender_burst = 1'b0;

  // Directed requests: empty-queue deletes, extremes, duplicates, ignored values
  request_row_t directed_rows [N_DIRECTED] = '{
    '{CMD_DEL_MIN, 32'sd0, 1'b1, EMPTY_RES},
    '{CMD_DEL_MAX, 32'sd0, 1'b1, EMPTY_RES},
    '{CMD_NOP, 32'sd0, 1'b1, EMPTY_RES},
    '{CMD_INSERT, MAX_INT, 1'b1, '{MAX_INT, MAX_INT, 1'b0, 1'b0}},
    '{CMD_INSERT, MIN_INT, 1'b1, '{MAX_INT, MIN_INT, 1'b0, 1'b0}},
    '{CMD_INSERT, 32'sd0, 1'b1, '{MAX_INT, MIN_INT, 1'b0, 1'b0}},
    '{CMD_INSERT, ALL_ONES, 1'b0, NO_RES},
    '{CMD_INSERT, 32'sd0, 1'b0, NO_RES},
    '{CMD_INSERT, MAX_INT, 1'b0, NO_RES},
    '{CMD_NOP, 32'sh55555555, 1'b0, NO_RES},
    '{CMD_DEL_MAX, 32'sd0, 1'b0, NO_RES},
    '{CMD_DEL_MAX, 32'sd0, 1'b0, NO_RES},
    '{CMD_DEL_MIN, 32'sd0, 1'b0, NO_RES},
    '{CMD_DEL_MIN, 32'sd0, 1'b0, NO_RES},
    '{CMD_DEL_MIN, 32'sd0, 1'b0, NO_RES},
    '{CMD_DEL_MAX, 32'sd0, 1'b1, EMPTY_RES},
    '{CMD_DEL_MAX, 32'sd0, 1'b1, EMPTY_RES},
    '{CMD_INSERT, MIN_INT, 1'b1, '{MIN_INT, MIN_INT, 1'b0, 1'b0}},
    '{CMD_INSERT, 32'shAAAAAAAA, 1'b0, NO_RES},
    '{CMD_DEL_MIN, ALL_ONES, 1'b0, NO_RES},
    '{CMD_DEL_MIN, 32'sd0, 1'b1, EMPTY_RES}
  };

  double_ended_priority_queue u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_max_value (out_max_value),
    .out_min_value (out_min_value),
    .out_is_empty  (out_is_empty),
    .out_rejected  (out_rejected)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  // Apply one request to the sorted multiset and return the result it causes
  function automatic queue_result_t apply_request(logic [1:0] cmd, data_t value);
    queue_result_t res;
    int slot;
    res = '0;
    case (cmd)
      CMD_INSERT: begin
        if (held_values.size() >= CAPACITY) begin
          res.rejected = 1'b1;
        end else begin
          // new copy goes above equal copies
          slot = held_values.size();
          while (slot > 0 && held_values[slot-1] > value) slot--;
          held_values.insert(slot, value);
        end
      end
      CMD_DEL_MIN: begin
        if (held_values.size() > 0) void'(held_values.pop_front());
      end
      CMD_DEL_MAX: begin
        if (held_values.size() > 0) void'(held_values.pop_back());
      end
      default: ;
    endcase
    if (held_values.size() == 0) begin
      res.is_empty = 1'b1;
    end else begin
      res.max_value = held_values[held_values.size()-1];
      res.min_value = held_values[0];
    end
    return res;
  endfunction

  // Values lean toward a narrow band for duplicates, plus extremes
  function automatic data_t pick_value();
    data_t v;
    case ($urandom_range(0, 3))
      0: v = $signed($urandom_range(0, 16)) - 32'sd8;
      1: begin
        case ($urandom_range(0, 3))
          0: v = MAX_INT;
          1: v = MIN_INT;
          2: v = ALL_ONES;
          default: v = 32'sd0;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [1:0] pick_cmd(int insert_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < insert_pct) return CMD_INSERT;
    if (r < 97) return ($urandom_range(0, 1) != 0) ? CMD_DEL_MIN : CMD_DEL_MAX;
    return CMD_NOP;
  endfunction

  task automatic report_mismatch(string field, int idx, data_t want, data_t got);
    $display("mismatch on result %0d, %s: expected %0d, got %0d", idx, field, want, got);
    mismatch_count++;
  endtask

  // Offer one request; starts and ends at a falling edge
  task automatic offer_request(input logic [1:0] cmd, input data_t value,
                               input logic typed, input queue_result_t want);
    int gap;
    queue_result_t predicted;
    gap = sender_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_value <= value;
    do @(posedge clk); while (in_stall);
    predicted = apply_request(cmd, value);
    pending_results.insert(pending_results.size(), typed ? want : predicted);
    @(negedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin : result_check
    queue_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", checked_count, 32'sd0, 32'sd1);
      end else begin
        want = pending_results.pop_front();
        if (out_max_value !== want.max_value)
          report_mismatch("max_value", checked_count, want.max_value, out_max_value);
        if (out_min_value !== want.min_value)
          report_mismatch("min_value", checked_count, want.min_value, out_min_value);
        if (out_is_empty !== want.is_empty)
          report_mismatch("is_empty", checked_count, data_t'(want.is_empty),
                          data_t'(out_is_empty));
        if (out_rejected !== want.rejected)
          report_mismatch("rejected", checked_count, data_t'(want.rejected),
                          data_t'(out_rejected));
      end
      checked_count++;
    end
  end

  // Result side: random stall per result, quiet stretches, one long hold-off
  initial begin : receiver
    int hold;
    out_stall = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (result_count == LONG_HOLD_AT) hold = LONG_HOLD_CYCLES;
      else if (((result_count / 40) % 3) == 2) hold = 0;
      else hold = $urandom_range(0, 15);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      result_count++;
      @(negedge clk);
    end
  end

  // Request side: directed table, then grow, shrink and mixed phases
  initial begin : sender
    int item_count;
    int insert_pct;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_INSERT;
    in_value = '0;
    item_count = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      sender_burst = (i % 8) >= 5;
      offer_request(directed_rows[i].cmd, directed_rows[i].value,
                    directed_rows[i].typed, directed_rows[i].want);
    end

    // grow past capacity, drain past empty, then mixed traffic
    for (int phase = 0; phase < 3; phase++) begin
      insert_pct = (phase == 0) ? 90 : (phase == 1) ? 8 : 50;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        sender_burst = ((item_count / 50) % 3) == 1;
        offer_request(pick_cmd(insert_pct), pick_value(), 1'b0, NO_RES);
        item_count++;
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
